/* src/cbs_pkg.sv */
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants of the credit-based shaper with descriptor ring.
// ----------------------------------------------------------------------------
`default_nettype none

package cbs_pkg;

   // field widths
   localparam int TIME_W   = 48;
   localparam int CREDIT_W = 48;
   localparam int ID_W     = 32;
   localparam int LEN_W    = 16;
   localparam int HOP_W    = 16;
   localparam int SLOPE_W  = 32;
   localparam int DESC_W   = ID_W + LEN_W + HOP_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;

   // input opcodes
   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_POLL    = 1'b1
   } opcode_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_SENT     = 3'd0,
      ST_BUSY     = 3'd1,
      ST_NOCREDIT = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_ENQUEUED = 3'd4,
      ST_DROPPED  = 3'd5,
      ST_DISABLED = 3'd6
   } status_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_SLOPE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_SLOPE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HI_CREDIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LO_CREDIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NS_PER_BYTE = 3'd5;

   // reset wire time: 8 ns per byte in Q16.16
   localparam logic [31:0] NS_PER_BYTE_RESET = 32'd524288;

endpackage

`default_nettype wire

/* src/cbs_req_if.sv */
// ----------------------------------------------------------------------------
// cbs_req_if
// Request channel: enqueue descriptors and polls, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbs_req_if import cbs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [TIME_W-1:0] now_ns;
   logic [ID_W-1:0]   packet_id;
   logic [LEN_W-1:0]  frame_len;
   logic [HOP_W-1:0]  next_hop;

   modport source (output valid, opcode, now_ns, packet_id, frame_len, next_hop,
                   input ready);
   modport sink   (input valid, opcode, now_ns, packet_id, frame_len, next_hop,
                   output ready);
endinterface

`default_nettype wire

/* src/cbs_rsp_if.sv */
// ----------------------------------------------------------------------------
// cbs_rsp_if
// Response channel: per-transaction results, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbs_rsp_if import cbs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [2:0]          status;
   logic [ID_W-1:0]     sent_id;
   logic [HOP_W-1:0]    sent_hop;
   logic [LEN_W-1:0]    sent_len;
   logic [CREDIT_W-1:0] credit_after;
   logic                last;

   modport source (output valid, status, sent_id, sent_hop, sent_len, credit_after, last,
                   input ready);
   modport sink   (input valid, status, sent_id, sent_hop, sent_len, credit_after, last,
                   output ready);
endinterface

`default_nettype wire

/* src/cbs_ram.sv */
// ----------------------------------------------------------------------------
// cbs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

/* src/credit_based_shaper_dequeue.sv */
// ----------------------------------------------------------------------------
// credit_based_shaper_dequeue
// Credit-based shaper over a descriptor ring held in a synchronous RAM.
// ----------------------------------------------------------------------------
// channel   dir   handshake      payload
// req_if    in    valid/ready    opcode, now_ns, packet_id, frame_len, next_hop
// rsp_if    out   valid/ready    status, sent_id, sent_hop, sent_len, credit_after, last
// csr_*     in    csr_we         csr_index, csr_wdata
//
// An enqueue passes from idle through the response state. A poll first adds the
// credit gain (the 48x32 gain product is built from two partial products), then steps
// per sent packet: ring read, wire time multiply, two cost multiplies, sum, commit.
// One transaction is worked on at a time; the request side is ready in idle.
// Response stalls hold the engine only where a result must be handed over.
// Reset is synchronous; the ring needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module credit_based_shaper_dequeue import cbs_pkg::*; #(
   parameter int RING_DEPTH = 1024,
   parameter int MAX_BURST  = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   cbs_req_if.sink                    req_if,
   cbs_rsp_if.source                  rsp_if,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam int NW = $clog2(MAX_BURST + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RESP, S_GAIN1, S_GAIN2, S_GAIN3, S_GAIN4,
      S_CHECK, S_READ, S_COST1, S_COST2, S_COST3, S_COMMIT
   } state_type;

   // configuration registers
   logic                       enable_ff;
   logic [SLOPE_W-1:0]         idle_slope_ff;
   logic signed [SLOPE_W-1:0]  send_slope_ff;
   logic signed [CREDIT_W-1:0] hi_credit_ff;
   logic signed [CREDIT_W-1:0] lo_credit_ff;
   logic [31:0]                ns_per_byte_ff;

   // control state
   state_type                  state_ff;
   logic [AW-1:0]              head_ff, tail_ff;
   logic [FW-1:0]              fill_ff;
   logic [NW-1:0]              sent_ff;
   logic signed [CREDIT_W-1:0] credit_ff;
   logic [TIME_W-1:0]          last_update_ff, busy_until_ff, allowed_ff;

   // transaction payload
   logic [TIME_W-1:0]          now_ff;
   logic [TIME_W:0]            elapsed_ff;
   logic [63:0]                gprod_lo_ff;
   logic [47:0]                gprod_hi_ff;
   logic [79:0]                gprod_ff;
   logic [DESC_W-1:0]          desc_ff;
   logic [47:0]                dur_ff;
   logic [32:0]                dur_ceil_ff;
   logic signed [56:0]         cost_a_ff, cost_b_ff;
   logic signed [57:0]         cost_ff;

   // pending result
   status_type                 res_status_ff;
   logic [ID_W-1:0]            res_id_ff;
   logic [HOP_W-1:0]           res_hop_ff;
   logic [LEN_W-1:0]           res_len_ff;
   logic [CREDIT_W-1:0]        res_credit_ff;

   // output register
   logic                       rsp_valid_ff;
   status_type                 rsp_status_ff;
   logic [ID_W-1:0]            rsp_id_ff;
   logic [HOP_W-1:0]           rsp_hop_ff;
   logic [LEN_W-1:0]           rsp_len_ff;
   logic [CREDIT_W-1:0]        rsp_credit_ff;
   logic                       rsp_last_ff;

   // ring
   logic [DESC_W-1:0]          ring_rdata;
   logic                       ring_we;

   // combinational helpers
   logic                       req_accept;
   logic                       out_free;
   logic                       rsp_load;
   logic                       ring_full;
   logic [AW-1:0]              head_inc_in, tail_inc_in;
   logic [TIME_W:0]            elapsed_in;
   logic signed [57:0]         gain_sum_in;
   logic signed [CREDIT_W-1:0] gain_credit_in;
   logic [TIME_W-1:0]          start_in;
   logic [TIME_W:0]            allowed_sum_in;
   logic [TIME_W-1:0]          allowed_in;
   logic signed [58:0]         credit_sum_in;
   logic signed [CREDIT_W-1:0] credit_sat_in;

   assign req_accept = req_if.valid && req_if.ready;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load   = out_free && ((state_ff == S_RESP) ||
                                    (state_ff == S_COMMIT && sent_ff != '0));
   assign ring_full  = (fill_ff == FW'(RING_DEPTH));
   assign ring_we    = req_accept && (req_if.opcode == OP_ENQUEUE) && !ring_full;

   assign head_inc_in = (head_ff == AW'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_inc_in = (tail_ff == AW'(RING_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   // elapsed time as a signed difference
   assign elapsed_in = {1'b0, req_if.now_ns} - {1'b0, last_update_ff};

   // credit plus idle gain, capped
   always_comb begin
      gain_sum_in = $signed({{10{credit_ff[CREDIT_W-1]}}, credit_ff})
                    + $signed({2'b00, gprod_ff[63:8]});
      if (gprod_ff[79:64] != '0) begin
         gain_credit_in = hi_credit_ff;
      end else if (gain_sum_in < $signed({{10{hi_credit_ff[CREDIT_W-1]}}, hi_credit_ff})) begin
         gain_credit_in = gain_sum_in[CREDIT_W-1:0];
      end else begin
         gain_credit_in = hi_credit_ff;
      end
   end

   // busy time advance, saturated
   always_comb begin
      start_in       = (now_ff > allowed_ff) ? now_ff : allowed_ff;
      allowed_sum_in = {1'b0, start_in} + {16'b0, dur_ceil_ff};
      allowed_in     = allowed_sum_in[TIME_W] ? '1 : allowed_sum_in[TIME_W-1:0];
   end

   // credit after packet cost, saturated to 48 bits
   always_comb begin
      credit_sum_in = {{11{credit_ff[CREDIT_W-1]}}, credit_ff} + {cost_ff[57], cost_ff};
      if (credit_sum_in[58:47] == '0 || credit_sum_in[58:47] == '1) begin
         credit_sat_in = credit_sum_in[CREDIT_W-1:0];
      end else if (credit_sum_in[58]) begin
         credit_sat_in = {1'b1, {(CREDIT_W-1){1'b0}}};
      end else begin
         credit_sat_in = {1'b0, {(CREDIT_W-1){1'b1}}};
      end
   end

   cbs_ram #(
      .WIDTH (DESC_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (tail_ff),
      .wdata ({req_if.next_hop, req_if.frame_len, req_if.packet_id}),
      .raddr (head_ff),
      .rdata (ring_rdata)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         idle_slope_ff  <= '0;
         send_slope_ff  <= '0;
         hi_credit_ff   <= '0;
         lo_credit_ff   <= '0;
         ns_per_byte_ff <= NS_PER_BYTE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:      enable_ff      <= csr_wdata[0];
            CSR_IDLE_SLOPE:  idle_slope_ff  <= csr_wdata[SLOPE_W-1:0];
            CSR_SEND_SLOPE:  send_slope_ff  <= csr_wdata[SLOPE_W-1:0];
            CSR_HI_CREDIT:   hi_credit_ff   <= csr_wdata[CREDIT_W-1:0];
            CSR_LO_CREDIT:   lo_credit_ff   <= csr_wdata[CREDIT_W-1:0];
            CSR_NS_PER_BYTE: ns_per_byte_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // sequencer, shaper state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         head_ff        <= '0;
         tail_ff        <= '0;
         fill_ff        <= '0;
         sent_ff        <= '0;
         credit_ff      <= '0;
         last_update_ff <= '0;
         busy_until_ff  <= '0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  now_ff        <= req_if.now_ns;
                  elapsed_ff    <= elapsed_in;
                  allowed_ff    <= busy_until_ff;
                  sent_ff       <= '0;
                  res_id_ff     <= '0;
                  res_hop_ff    <= '0;
                  res_len_ff    <= '0;
                  res_credit_ff <= credit_ff;
                  if (req_if.opcode == OP_ENQUEUE) begin
                     state_ff <= S_RESP;
                     if (ring_full) begin
                        res_status_ff <= ST_DROPPED;
                     end else begin
                        res_status_ff <= ST_ENQUEUED;
                        tail_ff       <= tail_inc_in;
                        fill_ff       <= fill_ff + 1'b1;
                     end
                  end else if (!enable_ff) begin
                     res_status_ff <= ST_DISABLED;
                     state_ff      <= S_RESP;
                  end else if (fill_ff == '0) begin
                     res_status_ff <= ST_EMPTY;
                     state_ff      <= S_RESP;
                  end else if ($signed(elapsed_in) > $signed((TIME_W+1)'(1))) begin
                     state_ff <= S_GAIN1;
                  end else begin
                     state_ff <= S_CHECK;
                  end
               end
            end

            // final result of the transaction
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_id_ff     <= res_id_ff;
                  rsp_hop_ff    <= res_hop_ff;
                  rsp_len_ff    <= res_len_ff;
                  rsp_credit_ff <= res_credit_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end

            // idle gain from two partial products
            S_GAIN1: begin
               gprod_lo_ff <= elapsed_ff[31:0] * idle_slope_ff;
               state_ff    <= S_GAIN2;
            end
            S_GAIN2: begin
               gprod_hi_ff <= elapsed_ff[47:32] * idle_slope_ff;
               state_ff    <= S_GAIN3;
            end
            S_GAIN3: begin
               gprod_ff <= {gprod_hi_ff, 32'b0} + {16'b0, gprod_lo_ff};
               state_ff <= S_GAIN4;
            end
            S_GAIN4: begin
               credit_ff      <= gain_credit_in;
               last_update_ff <= now_ff;
               state_ff       <= S_CHECK;
            end

            // burst control
            S_CHECK: begin
               res_credit_ff <= credit_ff;
               if (sent_ff == NW'(MAX_BURST) || fill_ff == '0) begin
                  busy_until_ff <= allowed_ff;
                  state_ff      <= S_RESP;
               end else if (now_ff < allowed_ff) begin
                  if (sent_ff == '0) begin
                     res_status_ff <= ST_BUSY;
                  end else begin
                     busy_until_ff <= allowed_ff;
                  end
                  state_ff <= S_RESP;
               end else if (credit_ff < lo_credit_ff && send_slope_ff <= 0) begin
                  if (sent_ff == '0) begin
                     res_status_ff <= ST_NOCREDIT;
                  end else begin
                     busy_until_ff <= allowed_ff;
                  end
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_READ;
               end
            end

            // head descriptor and its wire time
            S_READ: begin
               desc_ff  <= ring_rdata;
               dur_ff   <= ring_rdata[47:32] * ns_per_byte_ff;
               state_ff <= S_COST1;
            end
            S_COST1: begin
               cost_a_ff   <= $signed({1'b0, dur_ff[47:24]}) * send_slope_ff;
               dur_ceil_ff <= 33'(({1'b0, dur_ff} + 49'h0FFFF) >> 16);
               state_ff    <= S_COST2;
            end
            S_COST2: begin
               cost_b_ff  <= $signed({1'b0, dur_ff[23:0]}) * send_slope_ff;
               allowed_ff <= allowed_in;
               state_ff   <= S_COST3;
            end
            S_COST3: begin
               cost_ff  <= {cost_a_ff[56], cost_a_ff} + 58'(cost_b_ff >>> 24);
               state_ff <= S_COMMIT;
            end

            // hand over the previous sent result, keep this one pending
            S_COMMIT: begin
               if (sent_ff == '0 || out_free) begin
                  if (sent_ff != '0) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= res_status_ff;
                     rsp_id_ff     <= res_id_ff;
                     rsp_hop_ff    <= res_hop_ff;
                     rsp_len_ff    <= res_len_ff;
                     rsp_credit_ff <= res_credit_ff;
                     rsp_last_ff   <= 1'b0;
                  end
                  res_status_ff <= ST_SENT;
                  res_id_ff     <= desc_ff[31:0];
                  res_len_ff    <= desc_ff[47:32];
                  res_hop_ff    <= desc_ff[63:48];
                  res_credit_ff <= credit_sat_in;
                  credit_ff     <= credit_sat_in;
                  head_ff       <= head_inc_in;
                  fill_ff       <= fill_ff - 1'b1;
                  sent_ff       <= sent_ff + 1'b1;
                  state_ff      <= S_CHECK;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.sent_id      = rsp_id_ff;
   assign rsp_if.sent_hop     = rsp_hop_ff;
   assign rsp_if.sent_len     = rsp_len_ff;
   assign rsp_if.credit_after = rsp_credit_ff;
   assign rsp_if.last         = rsp_last_ff;

   // ring occupancy never exceeds its depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(RING_DEPTH))
      else $error("ring fill above depth");

   // an empty or full ring has head and tail at the same entry
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == FW'(RING_DEPTH)) |-> head_ff == tail_ff)
      else $error("ring pointers disagree with fill");

   // burst length stays within its limit
   assert property (@(posedge clock) disable iff (reset)
      sent_ff <= NW'(MAX_BURST))
      else $error("burst counter above limit");

   // the port busy time only moves forward
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> busy_until_ff >= $past(busy_until_ff))
      else $error("busy time went backwards");

endmodule

`default_nettype wire
